// ===== rtl/rcq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the rectangle collision query table.
// No dependencies; imported by every module of the block.
package rcq_pkg;

	localparam int SLOTS_DEF      = 64;
	localparam int NUM_TYPES_DEF  = 16;
	localparam int COORD_BITS_DEF = 16;

	localparam int SLOT_W = 6;
	localparam int TYPE_W = 4;
	localparam int MASK_W = 16;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic wr;
		logic ld;
		logic step;
		logic kill;
		logic fin;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic s1_match;
		logic s1_end;
		logic s1_vld;
		logic only_first;
	} dp_sts_t;

endpackage

// ===== rtl/rcq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the rectangle collision query table: request handshake and scan sequencing.
// Depends on rcq_pkg; drives rcq_datapath through dp_cmd_t, reads dp_sts_t.
module rcq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic             command,
	input  rcq_pkg::dp_sts_t sts,
	output rcq_pkg::dp_cmd_t cmd
);
	import rcq_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

	state_t state_q;
	logic   ready_q;

	assign req_ready = ready_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.wr = req_valid && ready_q && (command == CMD_WRITE);
				cmd.ld = req_valid && ready_q && (command == CMD_QUERY);
			end
			ST_SCAN: begin
				cmd.step = sts.out_free;
				cmd.kill = sts.out_free && sts.s1_match && sts.only_first;
			end
			ST_FLUSH: begin
				cmd.fin = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.ld) begin
						state_q <= ST_SCAN;
						ready_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (cmd.kill) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end else if (cmd.step && sts.s1_vld && sts.s1_end) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (cmd.fin) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== rtl/rcq_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the rectangle collision query table: entry memory, valid bits,
// scan pipeline, pending hit and result register. Depends on rcq_pkg.
module rcq_datapath #(
	parameter int SLOTS      = rcq_pkg::SLOTS_DEF,
	parameter int NUM_TYPES  = rcq_pkg::NUM_TYPES_DEF,
	parameter int COORD_BITS = rcq_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcq_pkg::dp_cmd_t              cmd,
	output rcq_pkg::dp_sts_t              sts,
	input  logic [rcq_pkg::SLOT_W-1:0]    slot,
	input  logic                          valid_req,
	input  logic signed [COORD_BITS-1:0]  rect_x,
	input  logic signed [COORD_BITS-1:0]  rect_y,
	input  logic signed [COORD_BITS-1:0]  rect_w,
	input  logic signed [COORD_BITS-1:0]  rect_h,
	input  logic [rcq_pkg::TYPE_W-1:0]    obj_type,
	input  logic [rcq_pkg::MASK_W-1:0]    type_mask,
	input  logic                          only_first,
	input  logic                          skip_self,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic                          hit,
	output logic [rcq_pkg::SLOT_W-1:0]    hit_slot,
	output logic [rcq_pkg::TYPE_W-1:0]    hit_type,
	output logic                          last
);
	import rcq_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int EW = COORD_BITS + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [EW-1:0]         xe;
		logic [EW-1:0]         ye;
		logic                  ne;
		logic [TYPE_W-1:0]     ty;
	} entry_t;

	entry_t            mem [SLOTS];
	logic [SLOTS-1:0]  vbits_q;

	entry_t            new_e;
	logic              in_range;
	logic [IW-1:0]     wr_idx;

	entry_t            qry_q;
	logic [MASK_W-1:0] mask_q;
	logic              only_first_q;
	logic              skip_q;
	logic [SLOT_W-1:0] self_q;

	logic [IW-1:0]     addr_q;
	logic              issued_q;
	logic              issue;

	entry_t            rd_s1;
	logic              vbit_s1;
	logic [IW-1:0]     idx_s1;
	logic              vld_s1;

	logic              pend_vld_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [TYPE_W-1:0] pend_type_q;

	logic              out_valid_q;
	logic              hit_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic [TYPE_W-1:0] hit_type_q;
	logic              last_q;

	logic signed [EW-1:0] qx_w, qy_w, qxe_w, qye_w, ex_w, ey_w, exe_w, eye_w;
	logic              meet;
	logic              type_ok;
	logic              is_self;
	logic              match;
	logic              out_free;
	logic              load_out;

	always_comb begin
		new_e.x  = rect_x;
		new_e.y  = rect_y;
		new_e.xe = EW'(rect_x) + EW'(rect_w);
		new_e.ye = EW'(rect_y) + EW'(rect_h);
		new_e.ne = (rect_w > 0) && (rect_h > 0);
		new_e.ty = obj_type;
	end

	assign in_range = 32'(slot) < SLOTS;
	assign wr_idx   = IW'(slot);

	assign qx_w  = EW'($signed(qry_q.x));
	assign qy_w  = EW'($signed(qry_q.y));
	assign qxe_w = $signed(qry_q.xe);
	assign qye_w = $signed(qry_q.ye);
	assign ex_w  = EW'($signed(rd_s1.x));
	assign ey_w  = EW'($signed(rd_s1.y));
	assign exe_w = $signed(rd_s1.xe);
	assign eye_w = $signed(rd_s1.ye);

	assign meet    = qry_q.ne && rd_s1.ne && (qx_w < exe_w) && (ex_w < qxe_w)
		&& (qy_w < eye_w) && (ey_w < qye_w);
	assign type_ok = (32'(rd_s1.ty) < NUM_TYPES) && mask_q[rd_s1.ty];
	assign is_self = skip_q && (32'(idx_s1) == 32'(self_q));
	assign match   = vld_s1 && vbit_s1 && !is_self && meet && type_ok;

	assign issue    = !issued_q && !cmd.kill;
	assign out_free = !out_valid_q || rsp_ready;
	assign load_out = cmd.fin || (cmd.step && match && (only_first_q || pend_vld_q));

	always_comb begin
		sts.out_free   = out_free;
		sts.s1_match   = match;
		sts.s1_end     = (idx_s1 == LAST_IDX);
		sts.s1_vld     = vld_s1;
		sts.only_first = only_first_q;
	end

	assign rsp_valid = out_valid_q;
	assign hit       = hit_q;
	assign hit_slot  = hit_slot_q;
	assign hit_type  = hit_type_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (cmd.wr && in_range && valid_req) begin
			mem[wr_idx] <= new_e;
		end
		if (cmd.step && issue) begin
			rd_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbits_q     <= '0;
			addr_q      <= '0;
			issued_q    <= 1'b0;
			vld_s1      <= 1'b0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr && in_range) begin
				vbits_q[wr_idx] <= valid_req;
			end
			if (cmd.ld) begin
				addr_q     <= '0;
				issued_q   <= 1'b0;
				vld_s1     <= 1'b0;
				pend_vld_q <= 1'b0;
			end else if (cmd.step) begin
				vld_s1 <= issue;
				if (issue) begin
					if (addr_q == LAST_IDX) begin
						issued_q <= 1'b1;
					end else begin
						addr_q <= addr_q + IW'(1);
					end
				end
				if (match && !only_first_q) begin
					pend_vld_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			qry_q        <= new_e;
			mask_q       <= type_mask;
			only_first_q <= only_first;
			skip_q       <= skip_self;
			self_q       <= slot;
		end
		if (cmd.step && issue) begin
			vbit_s1 <= vbits_q[addr_q];
			idx_s1  <= addr_q;
		end
		if (cmd.step && match) begin
			pend_slot_q <= SLOT_W'(idx_s1);
			pend_type_q <= rd_s1.ty;
		end
		if (cmd.fin) begin
			hit_q      <= pend_vld_q;
			hit_slot_q <= pend_vld_q ? pend_slot_q : '0;
			hit_type_q <= pend_vld_q ? pend_type_q : '0;
			last_q     <= 1'b1;
		end else if (cmd.step && match && only_first_q) begin
			hit_q      <= 1'b1;
			hit_slot_q <= SLOT_W'(idx_s1);
			hit_type_q <= rd_s1.ty;
			last_q     <= 1'b1;
		end else if (cmd.step && match && pend_vld_q) begin
			hit_q      <= 1'b1;
			hit_slot_q <= pend_slot_q;
			hit_type_q <= pend_type_q;
			last_q     <= 1'b0;
		end
	end

endmodule

// ===== rtl/rect_collision_query_table.sv =====
`timescale 1ns / 1ps
// Top level of the rectangle collision query table.
// Depends on rcq_pkg, rcq_ctrl and rcq_datapath.
//
// Request channel (req_valid/req_ready) carries one command word. A write word
// loads or clears one slot and produces no result. A query word scans every
// slot in order, one slot per cycle through a registered memory read, and
// produces one result word per hit, or a single word with hit low when
// nothing collides. The final word of a query has last high.
// Result channel (rsp_valid/rsp_ready) is fed from an output register.
//
// A query occupies the scan unit for its memory reads of every slot, one
// pipeline stage and a flush state; only_first ends it at the first hit.
// The scan advances only when the output register is free, so a stalled
// receiver stalls the scan without losing words. A new request is taken
// while the final result still waits in the output register.
//
// Reset clears all slot valid marks, the scan state and the output register;
// stored rectangles and types keep whatever they held.
module rect_collision_query_table #(
	parameter int SLOTS      = rcq_pkg::SLOTS_DEF,
	parameter int NUM_TYPES  = rcq_pkg::NUM_TYPES_DEF,
	parameter int COORD_BITS = rcq_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          command,
	input  logic [rcq_pkg::SLOT_W-1:0]    slot,
	input  logic                          valid_req,
	input  logic signed [COORD_BITS-1:0]  rect_x,
	input  logic signed [COORD_BITS-1:0]  rect_y,
	input  logic signed [COORD_BITS-1:0]  rect_w,
	input  logic signed [COORD_BITS-1:0]  rect_h,
	input  logic [rcq_pkg::TYPE_W-1:0]    obj_type,
	input  logic [rcq_pkg::MASK_W-1:0]    type_mask,
	input  logic                          only_first,
	input  logic                          skip_self,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic                          hit,
	output logic [rcq_pkg::SLOT_W-1:0]    hit_slot,
	output logic [rcq_pkg::TYPE_W-1:0]    hit_type,
	output logic                          last
);
	import rcq_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rcq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.command   (command),
		.sts       (sts),
		.cmd       (cmd)
	);

	rcq_datapath #(
		.SLOTS      (SLOTS),
		.NUM_TYPES  (NUM_TYPES),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.slot       (slot),
		.valid_req  (valid_req),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.obj_type   (obj_type),
		.type_mask  (type_mask),
		.only_first (only_first),
		.skip_self  (skip_self),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.hit        (hit),
		.hit_slot   (hit_slot),
		.hit_type   (hit_type),
		.last       (last)
	);

endmodule

// ===== rtl/rcq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the rectangle collision query table, bound to the top level.
// Depends on rcq_pkg and rect_collision_query_table.
module rcq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       command,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       hit,
	input logic [rcq_pkg::SLOT_W-1:0] hit_slot,
	input logic [rcq_pkg::TYPE_W-1:0] hit_type,
	input logic                       last
);
	import rcq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable({hit, hit_slot, hit_type, last}))
		else $error("result word changed while stalled");

	a_miss_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !hit |-> last)
		else $error("no-hit word not marked last");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !hit |-> (hit_slot == '0) && (hit_type == '0))
		else $error("no-hit word carries slot or type");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (command == CMD_QUERY) |=> !req_ready)
		else $error("request taken again right after a query");

endmodule

bind rect_collision_query_table rcq_checker u_rcq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.command   (command),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.hit       (hit),
	.hit_slot  (hit_slot),
	.hit_type  (hit_type),
	.last      (last)
);
